@@ rtl/core/ltc_pkg.sv @@
// ----------------------------------------------------------------------------
// ltc_pkg
// shared types and constants of the light timeout controller
// ----------------------------------------------------------------------------
package ltc_pkg;

  // field and state widths
  localparam int unsigned CntW   = 22;
  localparam int unsigned LightW = 5;
  localparam int unsigned PhaseW = 8;

  // blink spacing of the warning window
  localparam int unsigned WarnPeriod = 600;

  // residue of the countdown modulo the blink spacing
  localparam int unsigned ModW = $clog2(WarnPeriod);

  // reciprocal of the blink spacing, exact floor for every CntW-bit reload
  localparam int unsigned RecipShift = CntW + ModW;
  localparam int unsigned RecipW     = CntW + 1;
  localparam int unsigned ProdW      = CntW + RecipW;
  localparam int unsigned QuotW      = ProdW - RecipShift;
  localparam longint unsigned RecipMul =
    ((64'd1 << RecipShift) + 64'(WarnPeriod) - 64'd1) / 64'(WarnPeriod);

  // light patterns
  localparam logic [LightW-1:0] PatAllOn = LightW'(30);
  localparam logic [LightW-1:0] PatZone1 = LightW'(2);
  localparam logic [LightW-1:0] PatZone2 = LightW'(4);
  localparam logic [LightW-1:0] PatZone3 = LightW'(8);

  // register reset values
  localparam logic [CntW-1:0]   TimeoutRst = CntW'(72000);
  localparam logic [ModW-1:0]   TimeoutModRst = ModW'(72000 % WarnPeriod);
  localparam logic [CntW-1:0]   WarnWinRst = CntW'(3000);
  localparam logic [PhaseW-1:0] StatusPerRst = PhaseW'(10);

  // configuration register indexes
  typedef enum logic [1:0] {
    RegTimeout   = 2'd0,
    RegWarnWin   = 2'd1,
    RegStatusPer = 2'd2
  } cfg_reg_e;

  // configuration seen by the tick logic
  typedef struct packed {
    logic [CntW-1:0]   timeout;
    logic [ModW-1:0]   timeout_mod;
    logic [CntW-1:0]   warn_window;
    logic [PhaseW-1:0] status_period;
  } cfg_t;

  // button levels of one tick
  typedef struct packed {
    logic all_off;
    logic all_on;
    logic zone1;
    logic zone2;
    logic zone3;
  } btn_t;

  // result of one tick
  typedef struct packed {
    logic [LightW-1:0] light_drive;
    logic              report_valid;
    logic              report_on;
    logic              status_led;
  } res_t;

endpackage

@@ rtl/core/ltc_cfg.sv @@
// ----------------------------------------------------------------------------
// ltc_cfg
// configuration registers with the residue of the reload value
// ----------------------------------------------------------------------------
module ltc_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [1:0]                 cfg_index_i,
  input  logic [ltc_pkg::CntW-1:0]   cfg_data_i,
  output ltc_pkg::cfg_t              cfg_o
);

  logic [ltc_pkg::CntW-1:0]   timeout_q, timeout_d;
  logic [ltc_pkg::ModW-1:0]   tmod_q, tmod_d;
  logic [ltc_pkg::CntW-1:0]   warn_q, warn_d;
  logic [ltc_pkg::PhaseW-1:0] period_q, period_d;

  logic                       wr;
  logic [ltc_pkg::ProdW-1:0]  prod;
  logic [ltc_pkg::QuotW-1:0]  quot;
  logic [ltc_pkg::ModW-1:0]   back;
  logic [ltc_pkg::ModW-1:0]   resid;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i && cfg_ready_o;

  // reload modulo the blink spacing by reciprocal multiplication
  assign prod  = ltc_pkg::ProdW'(cfg_data_i) * ltc_pkg::ProdW'(ltc_pkg::RecipMul);
  assign quot  = ltc_pkg::QuotW'(prod >> ltc_pkg::RecipShift);
  assign back  = ltc_pkg::ModW'(quot) * ltc_pkg::ModW'(ltc_pkg::WarnPeriod);
  assign resid = cfg_data_i[ltc_pkg::ModW-1:0] - back;

  always_comb begin
    timeout_d = timeout_q;
    tmod_d    = tmod_q;
    warn_d    = warn_q;
    period_d  = period_q;
    if (wr) begin
      case (ltc_pkg::cfg_reg_e'(cfg_index_i))
        ltc_pkg::RegTimeout: begin
          timeout_d = cfg_data_i;
          tmod_d    = resid;
        end
        ltc_pkg::RegWarnWin:   warn_d   = cfg_data_i;
        ltc_pkg::RegStatusPer: period_d = cfg_data_i[ltc_pkg::PhaseW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= ltc_pkg::TimeoutRst;
      tmod_q    <= ltc_pkg::TimeoutModRst;
      warn_q    <= ltc_pkg::WarnWinRst;
      period_q  <= ltc_pkg::StatusPerRst;
    end else begin
      timeout_q <= timeout_d;
      tmod_q    <= tmod_d;
      warn_q    <= warn_d;
      period_q  <= period_d;
    end
  end

  assign cfg_o.timeout       = timeout_q;
  assign cfg_o.timeout_mod   = tmod_q;
  assign cfg_o.warn_window   = warn_q;
  assign cfg_o.status_period = period_q;

endmodule

@@ rtl/core/ltc_step.sv @@
// ----------------------------------------------------------------------------
// ltc_step
// per-tick light, countdown and report logic with its state registers
// ----------------------------------------------------------------------------
module ltc_step (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  ltc_pkg::btn_t btn_i,
  input  ltc_pkg::cfg_t cfg_i,
  output ltc_pkg::res_t res_o
);

  logic [ltc_pkg::CntW-1:0]   rem_q, rem_d;
  logic [ltc_pkg::ModW-1:0]   mod_q, mod_d;
  logic [ltc_pkg::LightW-1:0] light_q, light_d;
  logic [ltc_pkg::LightW-1:0] last_q, last_d;
  logic [ltc_pkg::PhaseW-1:0] phase_q, phase_d;

  logic [ltc_pkg::CntW-1:0]   rem1;
  logic [ltc_pkg::ModW-1:0]   mod1;
  logic [ltc_pkg::LightW-1:0] light1;
  logic [ltc_pkg::PhaseW-1:0] phase1;
  logic                       warn, period, report;

  always_comb begin
    // buttons in priority order
    rem1   = rem_q;
    mod1   = mod_q;
    light1 = light_q;
    if (btn_i.all_off) begin
      light1 = '0;
      rem1   = '0;
      mod1   = '0;
    end else if (btn_i.all_on || btn_i.zone1 || btn_i.zone2 || btn_i.zone3) begin
      rem1 = cfg_i.timeout;
      mod1 = cfg_i.timeout_mod;
      if (btn_i.all_on)     light1 = ltc_pkg::PatAllOn;
      else if (btn_i.zone1) light1 = light_q | ltc_pkg::PatZone1;
      else if (btn_i.zone2) light1 = light_q | ltc_pkg::PatZone2;
      else                  light1 = light_q | ltc_pkg::PatZone3;
    end

    // countdown
    warn        = (mod1 == '0) && (rem1 <= cfg_i.warn_window);
    rem_d       = rem1;
    mod_d       = mod1;
    light_d     = light1;
    res_o.light_drive = '0;
    if (rem1 != '0) begin
      res_o.light_drive = warn ? '0 : light1;
      rem_d = rem1 - 1'b1;
      mod_d = (mod1 == '0) ? ltc_pkg::ModW'(ltc_pkg::WarnPeriod - 1) : mod1 - 1'b1;
    end else begin
      light_d = '0;
    end

    // status period and reports
    phase1  = phase_q + 1'b1;
    period  = (phase1 == cfg_i.status_period);
    phase_d = period ? '0 : phase1;
    report  = (light_d != last_q) || period;
    last_d  = report ? light_d : last_q;

    res_o.report_valid = report;
    res_o.report_on    = report && (light_d != '0);
    res_o.status_led   = period && (light_d != '0) && (rem_d != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q   <= '0;
      mod_q   <= '0;
      light_q <= '0;
      last_q  <= '0;
      phase_q <= '0;
    end else if (fire_i) begin
      rem_q   <= rem_d;
      mod_q   <= mod_d;
      light_q <= light_d;
      last_q  <= last_d;
      phase_q <= phase_d;
    end
  end

endmodule

@@ rtl/core/light_timeout_controller_top.sv @@
// ----------------------------------------------------------------------------
// light_timeout_controller_top
// timed lighting controller, one tick per input beat
// ----------------------------------------------------------------------------
// each input beat is one tick with five button levels; each tick gives exactly
// one result beat. a beat passes an input register, then the tick logic, then
// the result register; one beat is taken per cycle as long as the result side
// does not stall. the result register is a one-deep stage; a stalled result
// stops the input register, which in turn still takes one more beat. a write
// to timeout_ticks also stores the reload value modulo the blink spacing (600),
// found in the write cycle by a reciprocal multiplication, which lets the
// countdown track its residue without a divider; the configuration channel is
// always ready
module light_timeout_controller_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,

  // configuration writes
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [1:0]                 cfg_index_i,
  input  logic [ltc_pkg::CntW-1:0]   cfg_data_i,

  // tick beats in
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       all_off_pressed_i,
  input  logic                       all_on_pressed_i,
  input  logic                       zone1_pressed_i,
  input  logic                       zone2_pressed_i,
  input  logic                       zone3_pressed_i,

  // result beats out
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [ltc_pkg::LightW-1:0] light_drive_o,
  output logic                       report_valid_o,
  output logic                       report_on_o,
  output logic                       status_led_o
);

  ltc_pkg::cfg_t cfg;
  ltc_pkg::btn_t btn_q;
  ltc_pkg::res_t res, res_q;
  logic          s1_valid_q;
  logic          s1_fire;
  logic          out_valid_q;

  // configuration registers
  ltc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // tick moves to the result register when that slot is free or draining
  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      btn_q.all_off <= all_off_pressed_i;
      btn_q.all_on  <= all_on_pressed_i;
      btn_q.zone1   <= zone1_pressed_i;
      btn_q.zone2   <= zone2_pressed_i;
      btn_q.zone3   <= zone3_pressed_i;
    end
  end

  // tick logic and state
  ltc_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (s1_fire),
    .btn_i  (btn_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign light_drive_o  = res_q.light_drive;
  assign report_valid_o = res_q.report_valid;
  assign report_on_o    = res_q.report_on;
  assign status_led_o   = res_q.status_led;

endmodule

@@ verif/light_timeout_controller_top_tb.sv @@
// ----------------------------------------------------------------------------
// light_timeout_controller_top_tb
// self-checking bench of the light timeout controller
// ----------------------------------------------------------------------------
// tick beats go in with directed and random button levels. a behavioural copy
// of the tick logic predicts one result beat per accepted tick, and every
// result beat is compared field by field with the oldest prediction. registers
// are only rewritten once the controller has drained
module light_timeout_controller_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // generous bound on the whole run, far above the slowest legal run
  localparam int unsigned CycleLimit  = 200000;
  // covers the pipeline, plus margin to catch stray result beats
  localparam int unsigned DrainCycles = 6;

  logic                       clk_i;
  logic                       rst_ni;

  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic [1:0]                 cfg_index_i;
  logic [ltc_pkg::CntW-1:0]   cfg_data_i;

  logic                       in_valid_i;
  logic                       in_ready_o;
  logic                       all_off_pressed_i;
  logic                       all_on_pressed_i;
  logic                       zone1_pressed_i;
  logic                       zone2_pressed_i;
  logic                       zone3_pressed_i;

  logic                       out_valid_o;
  logic                       out_ready_i;
  logic [ltc_pkg::LightW-1:0] light_drive_o;
  logic                       report_valid_o;
  logic                       report_on_o;
  logic                       status_led_o;

  // behavioural copy of the controller: registers and state
  logic [ltc_pkg::CntW-1:0]   reload_ticks;
  logic [ltc_pkg::CntW-1:0]   blink_window;
  logic [ltc_pkg::PhaseW-1:0] period_len;
  logic [ltc_pkg::CntW-1:0]   countdown;
  logic [ltc_pkg::LightW-1:0] lamp_pat;
  logic [ltc_pkg::LightW-1:0] reported_pat;
  logic [ltc_pkg::PhaseW-1:0] phase_cnt;

  // predicted result beats, oldest first
  ltc_pkg::res_t              res_due_q[$];

  int unsigned                err_cnt;
  int unsigned                cycle_cnt;
  int unsigned                send_idle_pct;
  int unsigned                recv_stall_pct;

  light_timeout_controller_top i_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // one tick of the controller: buttons, countdown, then reporting
  function automatic ltc_pkg::res_t step_lamps(ltc_pkg::btn_t b);
    ltc_pkg::res_t r;
    logic period_hit;
    logic announce;
    r = '0;
    // strict priority, only the highest held button acts
    if (b.all_off) begin
      lamp_pat  = '0;
      countdown = '0;
    end else if (b.all_on) begin
      lamp_pat  = ltc_pkg::PatAllOn;
      countdown = reload_ticks;
    end else if (b.zone1) begin
      lamp_pat  = lamp_pat | ltc_pkg::PatZone1;
      countdown = reload_ticks;
    end else if (b.zone2) begin
      lamp_pat  = lamp_pat | ltc_pkg::PatZone2;
      countdown = reload_ticks;
    end else if (b.zone3) begin
      lamp_pat  = lamp_pat | ltc_pkg::PatZone3;
      countdown = reload_ticks;
    end
    if (countdown != '0) begin
      // warning blank: count on the blink spacing and inside the window
      if ((countdown % ltc_pkg::WarnPeriod) == 0 && countdown <= blink_window) begin
        r.light_drive = '0;
      end else begin
        r.light_drive = lamp_pat;
      end
      countdown = countdown - 1'b1;
    end else begin
      // timed out, or a zero reload: pattern cleared on this very tick
      lamp_pat      = '0;
      r.light_drive = '0;
    end
    // phase wraps through 255, so a zero or lowered period still matches
    phase_cnt  = phase_cnt + 1'b1;
    period_hit = (phase_cnt == period_len);
    announce   = (lamp_pat != reported_pat) || period_hit;
    if (announce) begin
      reported_pat = lamp_pat;
    end
    if (period_hit) begin
      phase_cnt    = '0;
      r.status_led = (lamp_pat != '0) && (countdown != '0);
    end
    r.report_valid = announce;
    r.report_on    = announce && (lamp_pat != '0);
    return r;
  endfunction

  // random button levels; press_pct sets how often anything is held
  function automatic ltc_pkg::btn_t rand_tick(int unsigned press_pct);
    ltc_pkg::btn_t b;
    int unsigned   pick;
    b = '0;
    if ($urandom_range(99) < press_pct) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        b = {1'b1, 4'($urandom)};
      end else if (pick < 40) begin
        b = {2'b01, 3'($urandom)};
      end else if (pick < 85) begin
        case ($urandom_range(2))
          0:       b.zone1 = 1'b1;
          1:       b.zone2 = 1'b1;
          default: b.zone3 = 1'b1;
        endcase
      end else begin
        b = 5'($urandom);
      end
    end
    return b;
  endfunction

  task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // offer one tick beat; valid stays up across back-to-back beats
  task automatic send_tick(ltc_pkg::btn_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    {all_off_pressed_i, all_on_pressed_i, zone1_pressed_i, zone2_pressed_i,
     zone3_pressed_i} <= b;
    do @(posedge clk_i); while (!in_ready_o);
    res_due_q.push_back(step_lamps(b));
  endtask

  // sender holds off until every predicted beat has come back
  task automatic drain_ticks();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (res_due_q.size() != 0);
  endtask

  // one register write; more keeps valid up for a following write
  task automatic write_cfg(ltc_pkg::cfg_reg_e idx, logic [ltc_pkg::CntW-1:0] data,
                           bit more);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      ltc_pkg::RegTimeout:   reload_ticks = data;
      ltc_pkg::RegWarnWin:   blink_window = data;
      ltc_pkg::RegStatusPer: period_len   = data[ltc_pkg::PhaseW-1:0];
      default: ;
    endcase
    if (!more) begin
      cfg_valid_i <= 1'b0;
    end
  endtask

  task automatic program_regs(logic [ltc_pkg::CntW-1:0] tmo,
                              logic [ltc_pkg::CntW-1:0] win,
                              logic [ltc_pkg::PhaseW-1:0] per);
    write_cfg(ltc_pkg::RegTimeout, tmo, 1'b1);
    write_cfg(ltc_pkg::RegWarnWin, win, 1'b1);
    write_cfg(ltc_pkg::RegStatusPer, ltc_pkg::CntW'(per), 1'b0);
  endtask

  task automatic run_random(int unsigned n_ticks, int unsigned press_pct);
    for (int unsigned k = 0; k < n_ticks; k++) begin
      // halfway through, let everything come back before going on
      if (k == n_ticks / 2) begin
        drain_ticks();
      end
      send_tick(rand_tick(press_pct));
    end
    drain_ticks();
  endtask

  // priority order of the buttons at the reset settings
  // bit order of the literals: all_off, all_on, zone1, zone2, zone3
  task automatic test_buttons();
    set_idling(0, 0);
    send_tick(5'b00000);
    send_tick(5'b00100);
    send_tick(5'b00010);
    send_tick(5'b00001);
    send_tick(5'b00000);
    send_tick(5'b01000);
    send_tick(5'b10000);
    send_tick(5'b01100);
    send_tick(5'b00101);
    send_tick(5'b00011);
    send_tick(5'b11111);
    send_tick(5'b01111);
    send_tick(5'b00000);
    send_tick(5'b10000);
    drain_ticks();
  endtask

  // zero reload clears the pattern on the tick that switched it on
  task automatic test_zero_timeout();
    program_regs('0, '0, 8'd1);
    send_tick(5'b00100);
    send_tick(5'b01000);
    send_tick(5'b00000);
    send_tick(5'b00001);
    drain_ticks();
  endtask

  // count reaching the blink spacing inside and just outside the window
  task automatic test_warning_blink();
    program_regs(ltc_pkg::CntW'(601), ltc_pkg::CntW'(600), 8'd3);
    send_tick(5'b00010);
    send_tick(5'b00000);
    send_tick(5'b00000);
    send_tick(5'b10000);
    drain_ticks();
    write_cfg(ltc_pkg::RegTimeout, ltc_pkg::CntW'(600), 1'b1);
    write_cfg(ltc_pkg::RegWarnWin, ltc_pkg::CntW'(599), 1'b0);
    send_tick(5'b01000);
    send_tick(5'b00000);
    send_tick(5'b00100);
    send_tick(5'b00000);
    drain_ticks();
  endtask

  // random ticks under several settings and each idling mode
  task automatic test_random_phases();
    set_idling(0, 0);
    program_regs(ltc_pkg::CntW'(601), {ltc_pkg::CntW{1'b1}}, 8'd1);
    run_random(200, 45);

    set_idling(45, 0);
    program_regs({ltc_pkg::CntW{1'b1}}, {ltc_pkg::CntW{1'b1}}, 8'd255);
    run_random(150, 40);

    set_idling(0, 45);
    program_regs(ltc_pkg::CntW'(1), '0, 8'd7);
    run_random(200, 30);

    // zero period: a period tick only once every 256 ticks
    set_idling(19, 19);
    program_regs(ltc_pkg::CntW'(1201), ltc_pkg::CntW'(1200), 8'd0);
    run_random(300, 10);

    set_idling(0, 0);
    program_regs(ltc_pkg::TimeoutRst, ltc_pkg::WarnWinRst, ltc_pkg::StatusPerRst);
    run_random(100, 50);
  endtask

  // period written below the running phase, which then wraps through 255
  task automatic test_period_wrap();
    set_idling(19, 19);
    program_regs(ltc_pkg::CntW'(40), ltc_pkg::CntW'(100), 8'd200);
    while (phase_cnt < 8'd100) begin
      send_tick(rand_tick(20));
    end
    drain_ticks();
    write_cfg(ltc_pkg::RegStatusPer, ltc_pkg::CntW'(5), 1'b0);
    run_random(80, 20);
  endtask

  // result side stalls at random
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // compare every accepted result beat with the oldest prediction
  always @(posedge clk_i) begin
    ltc_pkg::res_t due;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (res_due_q.size() == 0) begin
        $error("result beat with none predicted: light_drive %0d", light_drive_o);
        err_cnt++;
      end else begin
        due = res_due_q.pop_front();
        if (light_drive_o !== due.light_drive) begin
          $error("light_drive: expected %0d, got %0d", due.light_drive, light_drive_o);
          err_cnt++;
        end
        if (report_valid_o !== due.report_valid) begin
          $error("report_valid: expected %0d, got %0d", due.report_valid, report_valid_o);
          err_cnt++;
        end
        if (report_on_o !== due.report_on) begin
          $error("report_on: expected %0d, got %0d", due.report_on, report_on_o);
          err_cnt++;
        end
        if (status_led_o !== due.status_led) begin
          $error("status_led: expected %0d, got %0d", due.status_led, status_led_o);
          err_cnt++;
        end
      end
    end
  end

  // watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_ni            <= 1'b0;
    cfg_valid_i       <= 1'b0;
    cfg_index_i       <= ltc_pkg::RegTimeout;
    cfg_data_i        <= '0;
    in_valid_i        <= 1'b0;
    all_off_pressed_i <= 1'b0;
    all_on_pressed_i  <= 1'b0;
    zone1_pressed_i   <= 1'b0;
    zone2_pressed_i   <= 1'b0;
    zone3_pressed_i   <= 1'b0;
    err_cnt           = 0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;

    // behavioural state after reset
    reload_ticks = ltc_pkg::TimeoutRst;
    blink_window = ltc_pkg::WarnWinRst;
    period_len   = ltc_pkg::StatusPerRst;
    countdown    = '0;
    lamp_pat     = '0;
    reported_pat = '0;
    phase_cnt    = '0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_buttons();
    test_zero_timeout();
    test_warning_blink();
    test_random_phases();
    test_period_wrap();

    drain_ticks();
    // quiet spell to catch any stray result beat
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
